// ===== rtl/tmc_pkg.sv =====
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared types, register codes and helpers of the tilemap pixel compositor.
// ----------------------------------------------------------------------------
package tmc_pkg;

    localparam int DEF_LAYER_RAM_WORDS = 32768;
    localparam int DEF_TILE_ROM_BYTES  = 524288;
    localparam int DEF_PALETTE_WORDS   = 4096;

    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

    typedef enum logic [1:0] {
        REQ_LRAM   = 2'd0,
        REQ_TILE   = 2'd1,
        REQ_PAL    = 2'd2,
        REQ_SAMPLE = 2'd3
    } req_code_t;

    typedef enum logic [2:0] {
        CFG_BG0_SX  = 3'd0,
        CFG_BG0_SY  = 3'd1,
        CFG_BG1_SX  = 3'd2,
        CFG_BG1_SY  = 3'd3,
        CFG_TXT_SX  = 3'd4,
        CFG_TXT_SY  = 3'd5,
        CFG_VIEW_X  = 3'd6,
        CFG_VIEW_Y  = 3'd7
    } cfg_code_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [18:0] address;
        logic [15:0] data;
        logic [8:0]  screen_x;
        logic [8:0]  screen_y;
        logic [15:0] road_pixel;
    } req_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [8:0] bg0_scroll_x;
        logic [8:0] bg0_scroll_y;
        logic [8:0] bg1_scroll_x;
        logic [8:0] bg1_scroll_y;
        logic [8:0] text_scroll_x;
        logic [8:0] text_scroll_y;
        logic [8:0] view_offset_x;
        logic [8:0] view_offset_y;
    } cfg_t;

    typedef struct packed {
        logic       push;
        logic [1:0] inflight;
    } back_status_t;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

endpackage

// ===== rtl/tilemap_pixel_compositor.sv =====
// ----------------------------------------------------------------------------
// tilemap_pixel_compositor
// Scrolling two-tilemap + road + text compositor with its own memories.
//
// Input queue (push/full) takes one item per cycle while full is low:
// layer RAM, tile ROM and palette writes, or pixel samples. Only samples
// produce a beat on the result queue (empty/pop); writes produce none.
// A sample passes through the input queue, map fetch, tile fetch, palette
// and result queue in that order. Throughput: one item per cycle while no
// sample waits for credit, through the render pipeline, with layer RAM held
// in three copies for six reads per pixel. Samples are released into the
// pipeline only while the 8-entry result queue has room for everything in
// flight, so a stalled receiver fills the result queue, then the input
// queue, and full rises; nothing is dropped.
// Reset clears scroll registers and queues; memories are not cleared and
// must be loaded before samples read them. Configuration writes (index 0..7)
// are always ready and should be issued only while the block is idle.
// ----------------------------------------------------------------------------
module tilemap_pixel_compositor #(
    parameter int LAYER_RAM_WORDS = tmc_pkg::DEF_LAYER_RAM_WORDS,
    parameter int TILE_ROM_BYTES  = tmc_pkg::DEF_TILE_ROM_BYTES,
    parameter int PALETTE_WORDS   = tmc_pkg::DEF_PALETTE_WORDS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  tmc_pkg::req_item_t req,
    output logic               empty,
    input  logic               pop,
    output tmc_pkg::pixel_t    pixel,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import tmc_pkg::*;

    cfg_t         cfg_reg;
    logic         issue, credit_ok;
    req_item_t    issue_item;
    pixel_t       back_pixel;
    back_status_t bstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BG0_SX: cfg_reg.bg0_scroll_x  <= cfg_data[8:0];
                CFG_BG0_SY: cfg_reg.bg0_scroll_y  <= cfg_data[8:0];
                CFG_BG1_SX: cfg_reg.bg1_scroll_x  <= cfg_data[8:0];
                CFG_BG1_SY: cfg_reg.bg1_scroll_y  <= cfg_data[8:0];
                CFG_TXT_SX: cfg_reg.text_scroll_x <= cfg_data[8:0];
                CFG_TXT_SY: cfg_reg.text_scroll_y <= cfg_data[8:0];
                CFG_VIEW_X: cfg_reg.view_offset_x <= cfg_data[8:0];
                CFG_VIEW_Y: cfg_reg.view_offset_y <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // result queue
    localparam int CW = OUTQ_AW + 1;

    pixel_t         oq_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] oq_rd_reg, oq_wr_reg;
    logic [CW-1:0]  oq_cnt_reg, oq_cnt_next;
    logic           do_pop;

    assign empty     = (oq_cnt_reg == '0);
    assign do_pop    = pop && !empty;
    assign pixel     = oq_reg[oq_rd_reg];
    assign credit_ok = (oq_cnt_reg + CW'(bstat.inflight)) < CW'(OUTQ_DEPTH);
    assign oq_cnt_next = oq_cnt_reg + CW'(bstat.push) - CW'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_rd_reg  <= '0;
            oq_wr_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (do_pop)
                oq_rd_reg <= oq_rd_reg + 1'b1;
            if (bstat.push)
                oq_wr_reg <= oq_wr_reg + 1'b1;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bstat.push)
            oq_reg[oq_wr_reg] <= back_pixel;
    end

    tmc_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req(req),
        .credit_ok(credit_ok), .issue(issue), .issue_item(issue_item)
    );

    tmc_back #(
        .LAYER_RAM_WORDS(LAYER_RAM_WORDS),
        .TILE_ROM_BYTES(TILE_ROM_BYTES),
        .PALETTE_WORDS(PALETTE_WORDS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .issue(issue),
        .item(issue_item), .pixel(back_pixel), .status(bstat)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.push |-> (oq_cnt_reg < CW'(OUTQ_DEPTH) || do_pop))
        else $error("result queue overflow");

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (oq_cnt_reg + CW'(bstat.inflight)) <= CW'(OUTQ_DEPTH))
        else $error("more samples in flight than result queue room");

    a_sample_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && issue_item.req_type == REQ_SAMPLE) |-> credit_ok)
        else $error("sample issued without credit");
`endif

endmodule

// ===== rtl/tmc_front.sv =====
// ----------------------------------------------------------------------------
// tmc_front
// Two-entry input queue; releases a write at once and a sample on credit.
// ----------------------------------------------------------------------------
module tmc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  tmc_pkg::req_item_t req,
    input  logic              credit_ok,
    output logic              issue,
    output tmc_pkg::req_item_t issue_item
);
    import tmc_pkg::*;

    req_item_t  q_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;

    assign full       = (cnt_reg == 2'd2);
    assign do_push    = push && !full;
    assign issue_item = q_reg[rd_ptr_reg];
    assign issue      = (cnt_reg != 2'd0) &&
                        ((issue_item.req_type != REQ_SAMPLE) || credit_ok);

    always_comb
    begin
        rd_ptr_next = issue   ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, issue};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= req;
    end

endmodule

// ===== rtl/tmc_lram.sv =====
// ----------------------------------------------------------------------------
// tmc_lram
// One copy of layer RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module tmc_lram #(
    parameter int WORDS = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(WORDS)-1:0] waddr,
    input  logic [15:0]              wdata,
    input  logic [$clog2(WORDS)-1:0] raddr_a,
    input  logic [$clog2(WORDS)-1:0] raddr_b,
    output logic [15:0]              rdata_a,
    output logic [15:0]              rdata_b
);
    logic [15:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/tmc_back.sv =====
// ----------------------------------------------------------------------------
// tmc_back
// Render pipeline: map fetch, tile/char fetch, layer mix + palette, color out.
// ----------------------------------------------------------------------------
module tmc_back #(
    parameter int LAYER_RAM_WORDS = tmc_pkg::DEF_LAYER_RAM_WORDS,
    parameter int TILE_ROM_BYTES  = tmc_pkg::DEF_TILE_ROM_BYTES,
    parameter int PALETTE_WORDS   = tmc_pkg::DEF_PALETTE_WORDS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tmc_pkg::cfg_t         cfg,
    input  logic                  issue,
    input  tmc_pkg::req_item_t    item,
    output tmc_pkg::pixel_t       pixel,
    output tmc_pkg::back_status_t status
);
    import tmc_pkg::*;

    localparam int LW = $clog2(LAYER_RAM_WORDS);
    localparam int TW = $clog2(TILE_ROM_BYTES);
    localparam int PW = $clog2(PALETTE_WORDS);

    // ---------------- issue: coordinates and map addresses
    logic [8:0]  vx, vy, bx0, by0, bx1, by1, tx, ty;
    logic [11:0] ti0, ti1, tit;
    logic        lram_we;
    logic [15:0] rd0a, rd0b, rd1a, rd1b, rd2a, rd2b;
    logic [15:0] chg_addr;

    always_comb
    begin
        vx  = item.screen_x + cfg.view_offset_x;
        vy  = item.screen_y + cfg.view_offset_y;
        bx0 = vx + cfg.bg0_scroll_x;
        by0 = vy + cfg.bg0_scroll_y;
        bx1 = vx + cfg.bg1_scroll_x;
        by1 = vy + cfg.bg1_scroll_y;
        tx  = vx + cfg.text_scroll_x;
        ty  = vy + cfg.text_scroll_y;
        ti0 = {by0[8:3], bx0[8:3]};
        ti1 = {by1[8:3], bx1[8:3]};
        tit = {ty[8:3], tx[8:3]};
    end

    assign lram_we = issue && (item.req_type == REQ_LRAM) &&
                     ({1'b0, item.address} < 20'(LAYER_RAM_WORDS));

    // three identical copies give six reads per pixel
    tmc_lram #(.WORDS(LAYER_RAM_WORDS)) u_lram0 (
        .clk(clk), .we(lram_we), .waddr(item.address[LW-1:0]), .wdata(item.data),
        .raddr_a(LW'({3'b000, ti0, 1'b0})), .raddr_b(LW'({3'b000, ti0, 1'b1})),
        .rdata_a(rd0a), .rdata_b(rd0b)
    );
    tmc_lram #(.WORDS(LAYER_RAM_WORDS)) u_lram1 (
        .clk(clk), .we(lram_we), .waddr(item.address[LW-1:0]), .wdata(item.data),
        .raddr_a(LW'({3'b010, ti1, 1'b0})), .raddr_b(LW'({3'b010, ti1, 1'b1})),
        .rdata_a(rd1a), .rdata_b(rd1b)
    );
    tmc_lram #(.WORDS(LAYER_RAM_WORDS)) u_lram2 (
        .clk(clk), .we(lram_we), .waddr(item.address[LW-1:0]), .wdata(item.data),
        .raddr_a(LW'({4'b0010, tit})), .raddr_b(chg_addr[LW-1:0]),
        .rdata_a(rd2a), .rdata_b(rd2b)
    );

    // ---------------- stage 1: tile and character row fetch
    logic        s1_valid_reg;
    logic [1:0]  s1_req_reg;
    logic [18:0] s1_addr_reg;
    logic [15:0] s1_data_reg, s1_road_reg;
    logic [2:0]  s1_bx0_reg, s1_by0_reg, s1_bx1_reg, s1_by1_reg, s1_tx_reg, s1_ty_reg;

    logic [2:0]  x0f, y0f, x1f, y1f, txf, tyf;
    logic [18:0] ta0, ta1;
    logic        tile_we;
    logic [7:0]  tile_mem [TILE_ROM_BYTES];
    logic [7:0]  tb0_reg, tb1_reg;

    always_comb
    begin
        x0f = rd0a[14] ? ~s1_bx0_reg : s1_bx0_reg;
        y0f = rd0a[15] ? ~s1_by0_reg : s1_by0_reg;
        x1f = rd1a[14] ? ~s1_bx1_reg : s1_bx1_reg;
        y1f = rd1a[15] ? ~s1_by1_reg : s1_by1_reg;
        txf = rd2a[14] ? ~s1_tx_reg : s1_tx_reg;
        tyf = rd2a[15] ? ~s1_ty_reg : s1_ty_reg;
        ta0 = {rd0b[13:0], y0f, x0f[2:1]};
        ta1 = {rd1b[13:0], y1f, x1f[2:1]};
        chg_addr = {5'b00110, rd2a[7:0], tyf};
    end

    assign tile_we = s1_valid_reg && (s1_req_reg == REQ_TILE) &&
                     ({1'b0, s1_addr_reg} < 20'(TILE_ROM_BYTES));

    always_ff @(posedge clk)
    begin
        if (tile_we)
            tile_mem[s1_addr_reg[TW-1:0]] <= s1_data_reg[7:0];
        tb0_reg <= tile_mem[ta0[TW-1:0]];
        tb1_reg <= tile_mem[ta1[TW-1:0]];
    end

    // ---------------- stage 2: pen decode, layer mix, palette lookup
    logic        s2_valid_reg;
    logic [1:0]  s2_req_reg;
    logic [18:0] s2_addr_reg;
    logic [15:0] s2_data_reg, s2_road_reg;
    logic [7:0]  s2_col0_reg, s2_col1_reg;
    logic [5:0]  s2_tcol_reg;
    logic [2:0]  s2_tx_reg;
    logic        s2_nib0_reg, s2_nib1_reg, s2_in0_reg, s2_in1_reg;

    logic [3:0]  pen0, pen1;
    logic [1:0]  tpen;
    logic [11:0] pidx;
    logic        pal_we;
    logic [15:0] pal_mem [PALETTE_WORDS];
    logic [15:0] pal_rd_reg;

    always_comb
    begin
        pen0 = s2_in0_reg ? (s2_nib0_reg ? tb0_reg[3:0] : tb0_reg[7:4]) : 4'd0;
        pen1 = s2_in1_reg ? (s2_nib1_reg ? tb1_reg[3:0] : tb1_reg[7:4]) : 4'd0;
        tpen = {rd2b[3'd7 - s2_tx_reg], rd2b[4'd15 - {1'b0, s2_tx_reg}]};
        pidx = {s2_col0_reg, pen0};
        if (pen1 != 4'd0)
            pidx = {s2_col1_reg, pen1};
        if (!s2_road_reg[15])
            pidx = s2_road_reg[11:0];
        if (tpen != 2'd0)
            pidx = {4'd0, s2_tcol_reg, tpen};
    end

    assign pal_we = s2_valid_reg && (s2_req_reg == REQ_PAL) &&
                    ({1'b0, s2_addr_reg} < 20'(PALETTE_WORDS));

    always_ff @(posedge clk)
    begin
        if (pal_we)
            pal_mem[s2_addr_reg[PW-1:0]] <= s2_data_reg;
        pal_rd_reg <= pal_mem[pidx[PW-1:0]];
    end

    // ---------------- stage 3: color expand
    logic s3_valid_reg;

    assign pixel.red   = expand5(pal_rd_reg[14:10]);
    assign pixel.green = expand5(pal_rd_reg[9:5]);
    assign pixel.blue  = expand5(pal_rd_reg[4:0]);

    logic s1_smp, s2_smp;
    assign s1_smp = s1_valid_reg && (s1_req_reg == REQ_SAMPLE);
    assign s2_smp = s2_valid_reg && (s2_req_reg == REQ_SAMPLE);

    assign status.push     = s3_valid_reg;
    assign status.inflight = {1'b0, s1_smp} + {1'b0, s2_smp} + {1'b0, s3_valid_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_smp;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_req_reg  <= item.req_type;
        s1_addr_reg <= item.address;
        s1_data_reg <= item.data;
        s1_road_reg <= item.road_pixel;
        s1_bx0_reg  <= bx0[2:0];
        s1_by0_reg  <= by0[2:0];
        s1_bx1_reg  <= bx1[2:0];
        s1_by1_reg  <= by1[2:0];
        s1_tx_reg   <= tx[2:0];
        s1_ty_reg   <= ty[2:0];

        s2_req_reg  <= s1_req_reg;
        s2_addr_reg <= s1_addr_reg;
        s2_data_reg <= s1_data_reg;
        s2_road_reg <= s1_road_reg;
        s2_col0_reg <= rd0a[7:0];
        s2_col1_reg <= rd1a[7:0];
        s2_tcol_reg <= rd2a[13:8];
        s2_tx_reg   <= txf;
        s2_nib0_reg <= x0f[0];
        s2_nib1_reg <= x1f[0];
        s2_in0_reg  <= ({1'b0, ta0} < 20'(TILE_ROM_BYTES));
        s2_in1_reg  <= ({1'b0, ta1} < 20'(TILE_ROM_BYTES));
    end

endmodule

// ===== verif/tb_tilemap_pixel_compositor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tilemap_pixel_compositor
// Loads the block's memories on demand, samples pixels under several scroll
// and view settings, and checks every composited pixel against a local model
// of the four layers and the palette, with random gaps on both queues.
// ----------------------------------------------------------------------------
module tb_tilemap_pixel_compositor;
    import tmc_pkg::*;

    localparam int LRAM_WORDS = DEF_LAYER_RAM_WORDS;
    localparam int TROM_BYTES = DEF_TILE_ROM_BYTES;
    localparam int PAL_WORDS  = DEF_PALETTE_WORDS;
    localparam int BG0_MAP    = 'h0000;
    localparam int TEXT_MAP   = 'h2000;
    localparam int CHARGEN    = 'h3000;
    localparam int BG1_MAP    = 'h4000;
    localparam int STALL_LIMIT = 5000;

    class pixel_scoreboard;
        bit [15:0] lram[int];
        bit [7:0]  trom[int];
        bit [15:0] pal[int];
        bit [8:0]  regs[8];
        pixel_t    pixels_due[$];
        int        errors;
        req_code_t gap_kind;
        int        gap_addr;
        bit        gap_found;

        function void set_reg(cfg_code_t idx, bit [8:0] v);
            regs[idx] = v;
        endfunction

        // reads note the first entry that was never loaded
        function bit [15:0] rd_lram(int a);
            if (a >= LRAM_WORDS) return 0;
            if (!lram.exists(a)) begin
                if (!gap_found) begin gap_found = 1; gap_kind = REQ_LRAM; gap_addr = a; end
                return 0;
            end
            return lram[a];
        endfunction

        function bit [7:0] rd_trom(int a);
            if (a >= TROM_BYTES) return 0;
            if (!trom.exists(a)) begin
                if (!gap_found) begin gap_found = 1; gap_kind = REQ_TILE; gap_addr = a; end
                return 0;
            end
            return trom[a];
        endfunction

        function bit [15:0] rd_pal(int a);
            if (!pal.exists(a)) begin
                if (!gap_found) begin gap_found = 1; gap_kind = REQ_PAL; gap_addr = a; end
                return 0;
            end
            return pal[a];
        endfunction

        function int bg_lookup(int base, int wx, int wy, output int pen);
            int i, attr, code, x, y, a;
            bit [7:0] b;
            i = (wy >> 3) * 64 + (wx >> 3);
            attr = rd_lram(base + 2 * i);
            code = rd_lram(base + 2 * i + 1);
            x = wx & 7;
            y = wy & 7;
            if (attr & 'h4000) x = 7 - x;
            if (attr & 'h8000) y = 7 - y;
            a = (code * 32 + y * 4 + (x >> 1)) & 'h7ffff;
            b = rd_trom(a);
            pen = (x & 1) ? b[3:0] : b[7:4];
            return ((attr & 'hff) * 16 + pen) & 'hfff;
        endfunction

        function int text_lookup(int wx, int wy, output int pen);
            int w, x, y, row;
            w = rd_lram(TEXT_MAP + (wy >> 3) * 64 + (wx >> 3));
            x = wx & 7;
            y = wy & 7;
            if (w & 'h4000) x = 7 - x;
            if (w & 'h8000) y = 7 - y;
            row = rd_lram(CHARGEN + (w & 'hff) * 8 + y);
            pen = (((row >> 8) >> (7 - x)) & 1) | ((((row & 'hff) >> (7 - x)) & 1) << 1);
            return ((((w >> 8) & 'h3f) * 4) + pen) & 'hfff;
        endfunction

        // composites one sample; gap_found tells whether unloaded memory was read
        function pixel_t render_pixel(req_item_t it);
            int vx, vy, pen, idx;
            bit [15:0] c;
            pixel_t px;
            gap_found = 0;
            vx = it.screen_x + regs[CFG_VIEW_X];
            vy = it.screen_y + regs[CFG_VIEW_Y];
            idx = bg_lookup(BG0_MAP, (vx + regs[CFG_BG0_SX]) & 511,
                            (vy + regs[CFG_BG0_SY]) & 511, pen);
            c = rd_pal(idx);
            idx = bg_lookup(BG1_MAP, (vx + regs[CFG_BG1_SX]) & 511,
                            (vy + regs[CFG_BG1_SY]) & 511, pen);
            if (pen != 0) c = rd_pal(idx);
            if (!it.road_pixel[15]) c = rd_pal(it.road_pixel[11:0]);
            idx = text_lookup((vx + regs[CFG_TXT_SX]) & 511, (vy + regs[CFG_TXT_SY]) & 511, pen);
            if (pen != 0) c = rd_pal(idx);
            px.red   = {c[14:10], c[14:12]};
            px.green = {c[9:5], c[9:7]};
            px.blue  = {c[4:0], c[4:2]};
            return px;
        endfunction

        function void note_item(req_item_t it);
            case (req_code_t'(it.req_type))
                REQ_LRAM:   if (it.address < LRAM_WORDS) lram[it.address] = it.data;
                REQ_TILE:   if (it.address < TROM_BYTES) trom[it.address] = it.data[7:0];
                REQ_PAL:    if (it.address < PAL_WORDS) pal[it.address] = it.data;
                REQ_SAMPLE: pixels_due.push_back(render_pixel(it));
            endcase
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pixels_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected pixel beat %h", got);
                return;
            end
            want = pixels_due.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("pixel mismatch: exp r%h g%h b%h, got r%h g%h b%h",
                             want.red, want.green, want.blue, got.red, got.green, got.blue);
            end
        endfunction
    endclass

    logic      clk = 0;
    logic      rst_n = 0;
    logic      push = 0;
    logic      full;
    req_item_t req = '0;
    logic      empty;
    logic      pop = 0;
    pixel_t    pixel;
    logic      cfg_valid = 0;
    logic      cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    pixel_scoreboard sb = new();
    int send_idle, recv_idle, stall_cycles;
    int last_x, last_y;

    tilemap_pixel_compositor dut (.*);

    always #1 clk = ~clk;

    always begin
        @(posedge clk);
        if (rst_n && pop && !empty) sb.check_pixel(pixel);
        @(negedge clk);
        pop <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else if (rst_n && ++stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_item(req_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle) begin
            push <= 0;
            @(negedge clk);
        end
        push <= 1;
        req  <= it;
        do @(posedge clk); while (full);
        sb.note_item(it);
    endtask

    task automatic send_write(req_code_t kind, int addr, bit [15:0] d);
        req_item_t it;
        it = '0;
        it.req_type = kind;
        it.address  = addr;
        it.data     = d;
        it.screen_x = $urandom;
        it.screen_y = $urandom;
        it.road_pixel = $urandom;
        send_item(it);
    endtask

    // loads whatever the sample would read first, then sends it
    task automatic send_sample(bit [8:0] sx, bit [8:0] sy, bit [15:0] road);
        req_item_t it;
        pixel_t dummy;
        it = '0;
        it.req_type = REQ_SAMPLE;
        it.address  = $urandom;
        it.data     = $urandom;
        it.screen_x = sx;
        it.screen_y = sy;
        it.road_pixel = road;
        forever begin
            dummy = sb.render_pixel(it);
            if (!sb.gap_found) break;
            send_write(sb.gap_kind, sb.gap_addr, $urandom);
        end
        send_item(it);
    endtask

    task automatic write_reg(cfg_code_t idx, bit [15:0] v);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, v[8:0]);
    endtask

    task automatic drain;
        @(negedge clk);
        push <= 0;
        while (sb.pixels_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // phase 0 min, 1 max, else random with a few extremes
    task automatic set_view(int phase);
        cfg_code_t r;
        bit [15:0] v;
        for (int i = 0; i < 8; i++) begin
            r = cfg_code_t'(i);
            if (phase == 0) v = 0;
            else if (phase == 1) v = 16'h01ff;
            else if ($urandom_range(3) == 0) v = $urandom_range(1) ? 16'hffff : 16'h0000;
            else v = $urandom;
            write_reg(r, v);
        end
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // each fresh sample drags in several loads, so counts here stay small
    task automatic random_items(int n);
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                if ($urandom_range(1)) begin
                    last_x = (last_x + $urandom_range(15)) & 511;
                    last_y = (last_y + $urandom_range(3)) & 511;
                end else begin
                    last_x = $urandom_range(511);
                    last_y = $urandom_range(511);
                end
                send_sample(last_x, last_y, $urandom);
            end else if (pick < 75) send_write(REQ_LRAM, $urandom_range(LRAM_WORDS - 1), $urandom);
            else if (pick < 83) send_write(REQ_TILE, $urandom_range(TROM_BYTES - 1), $urandom);
            else if (pick < 90) send_write(REQ_PAL, $urandom_range(PAL_WORDS - 1), $urandom);
            else if (pick < 94) send_write(REQ_LRAM, $urandom_range(524287, LRAM_WORDS), $urandom);
            else if (pick < 97) send_write(REQ_PAL, $urandom_range(524287, PAL_WORDS), $urandom);
            else send_sample($urandom, $urandom, 16'h8000 | $urandom);
        end
    endtask

    initial begin
        send_idle = 22;
        recv_idle = 50;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: both flips, widest color, tile code that wraps the ROM
        set_view(0);
        send_write(REQ_LRAM, BG0_MAP, 16'hc0ff);
        send_write(REQ_LRAM, BG0_MAP + 1, 16'hffff);
        send_write(REQ_LRAM, BG1_MAP, 16'h40ff);
        send_write(REQ_LRAM, TEXT_MAP, 16'hffff);
        send_write(REQ_TILE, 524287, 16'hff5a);
        send_write(REQ_PAL, 4095, 16'hffff);
        send_write(REQ_PAL, 0, 16'h0000);
        // out-of-range writes are dropped
        send_write(REQ_LRAM, 524287, 16'h1234);
        send_write(REQ_PAL, 524287, 16'h4321);
        send_sample(0, 0, 16'h8000);
        send_sample(0, 0, 16'h0fff);
        send_sample(0, 0, 16'h7000);
        send_sample(511, 511, 16'hffff);
        send_sample(511, 0, 16'h0000);
        send_sample(0, 511, 16'h8fff);
        send_sample(7, 7, 16'h0abc);
        drain();
        set_view(1);
        send_sample(0, 0, 16'hffff);
        send_sample(511, 511, 16'h0001);
        send_sample(1, 510, 16'h8000);
        random_items(50);
        drain();

        send_idle = 50;
        recv_idle = 22;
        set_view(2);
        random_items(50);
        drain();

        send_idle = 0;
        recv_idle = 0;
        set_view(3);
        random_items(50);
        @(negedge clk);
        push <= 0;
        while (sb.pixels_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
